// ===== rtl/core/sha1_pkg.sv =====
package sha1_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha1_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha1_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_PADDING,
    ST_EMIT
  } sha1_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       wr_byte;
    logic [7:0] wr_data;
    logic       add_len;
    logic       start_block;
    logic       round_step;
    logic       finish_block;
    logic       latch_len;
    logic       reinit;
  } sha1_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] count;
    logic       last_round;
    logic [7:0] len_byte;
  } sha1_stat_t;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS = 6'd56;
  localparam logic [6:0]  LAST_ROUND = 7'd79;

endpackage

// ===== rtl/core/sha1_datapath.sv =====
module sha1_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  sha1_pkg::sha1_cmd_t cmd,
  input  logic [2:0]          word_sel,
  output sha1_pkg::sha1_stat_t stat,
  output logic [31:0]         digest_word
);
  import sha1_pkg::*;

  logic [31:0] blk_r [16];
  logic [31:0] w_r [16];
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [5:0]  count_r;
  logic [63:0] len_r;
  logic [63:0] len_hold_r;
  logic [6:0]  round_r;

  logic [31:0] w_new, wt, f, k, tmp;

  always_comb begin
    w_new = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    w_new = {w_new[30:0], w_new[31]};
    wt = (round_r < 7'd16) ? w_r[0] : w_new;
    if (round_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = K0;
    end else if (round_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = K1;
    end else if (round_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = K3;
    end
    tmp = {a_r[26:0], a_r[31:27]} + f + e_r + k + wt;
  end

  // The window shifts down one word per round; word t sits at index 0 for rounds 0-15, word t-16 after that.
  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      blk_r[count_r[5:2]] <= {blk_r[count_r[5:2]][23:0], cmd.wr_data};
    end
    if (cmd.start_block) begin
      for (int i = 0; i < 15; i++) w_r[i] <= blk_r[i];
      // The block starts on the beat that writes its last byte.
      w_r[15] <= {blk_r[15][23:0], cmd.wr_data};
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wt;
      a_r <= tmp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
    if (cmd.latch_len) len_hold_r <= len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      h_r[0] <= H0_INIT;
      h_r[1] <= H1_INIT;
      h_r[2] <= H2_INIT;
      h_r[3] <= H3_INIT;
      h_r[4] <= H4_INIT;
      count_r <= '0;
      len_r <= '0;
      round_r <= '0;
    end else begin
      if (cmd.wr_byte) count_r <= count_r + 6'd1;
      if (cmd.add_len) len_r <= len_r + 64'd8;
      if (cmd.start_block) round_r <= '0;
      else if (cmd.round_step) round_r <= round_r + 7'd1;
      // The last round's results are added as they form.
      if (cmd.finish_block) begin
        h_r[0] <= h_r[0] + tmp;
        h_r[1] <= h_r[1] + a_r;
        h_r[2] <= h_r[2] + {b_r[1:0], b_r[31:2]};
        h_r[3] <= h_r[3] + c_r;
        h_r[4] <= h_r[4] + d_r;
      end
    end
  end

  always_comb begin
    stat.count = count_r;
    stat.last_round = (round_r == LAST_ROUND);
    stat.len_byte = len_hold_r[8*(7-count_r[2:0]) +: 8];
  end

  assign digest_word = h_r[word_sel];

endmodule

// ===== rtl/core/sha1_ctrl.sv =====
module sha1_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sha1_pkg::sha1_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           word_sel,
  output logic                 last_word,
  output sha1_pkg::sha1_cmd_t  cmd,
  input  sha1_pkg::sha1_stat_t stat
);
  import sha1_pkg::*;

  sha1_state_t state_r, state_nxt;
  logic        ending_r, ending_nxt;
  logic        padded_r, padded_nxt;
  logic        extra_blk_r, extra_blk_nxt;
  logic [2:0]  word_r, word_nxt;
  logic        accept, pad_block_done;

  assign accept = in_valid && (state_r == ST_IDLE);
  assign pad_block_done = cmd.wr_byte && (stat.count == 6'd63);

  always_comb begin
    state_nxt = state_r;
    ending_nxt = ending_r;
    padded_nxt = padded_r;
    extra_blk_nxt = extra_blk_r;
    word_nxt = word_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ending_nxt = in_data.end_of_message;
          padded_nxt = 1'b0;
          extra_blk_nxt = 1'b0;
          if (in_data.byte_present && stat.count == 6'd63) state_nxt = ST_ROUND;
          else if (in_data.end_of_message) state_nxt = ST_PADDING;
        end
      end
      ST_ROUND: begin
        if (stat.last_round) begin
          if (!ending_r) state_nxt = ST_IDLE;
          else if (padded_r && !extra_blk_r) begin
            state_nxt = ST_EMIT;
            word_nxt = '0;
          end else begin
            state_nxt = ST_PADDING;
            extra_blk_nxt = 1'b0;
          end
        end
      end
      ST_PADDING: begin
        padded_nxt = 1'b1;
        // A 0x80 at or past the length field pushes the length into one more block.
        if (!padded_r && stat.count >= LEN_POS) extra_blk_nxt = 1'b1;
        if (pad_block_done) state_nxt = ST_ROUND;
      end
      ST_EMIT: begin
        if (!out_stall) begin
          word_nxt = word_r + 3'd1;
          if (word_r == 3'd4) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state_r != ST_IDLE);
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_data.byte_present) begin
          cmd.wr_byte = 1'b1;
          cmd.wr_data = in_data.data_byte;
          cmd.add_len = 1'b1;
        end
        cmd.start_block = accept && in_data.byte_present && stat.count == 6'd63;
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        cmd.finish_block = stat.last_round;
      end
      ST_PADDING: begin
        cmd.wr_byte = 1'b1;
        if (!padded_r) cmd.wr_data = PAD_BYTE;
        else if (stat.count >= LEN_POS && !extra_blk_r) cmd.wr_data = stat.len_byte;
        else cmd.wr_data = 8'h00;
        // The first pad byte after a byte on this item still needs the new length.
        cmd.latch_len = !padded_r;
        cmd.start_block = pad_block_done;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.reinit = !out_stall && word_r == 3'd4;
      end
      default: ;
    endcase
  end

  // Zeros run until the length field; padded_r marks that 0x80 is in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ending_r <= 1'b0;
      padded_r <= 1'b0;
      extra_blk_r <= 1'b0;
      word_r <= '0;
    end else begin
      state_r <= state_nxt;
      ending_r <= ending_nxt;
      padded_r <= padded_nxt;
      extra_blk_r <= extra_blk_nxt;
      word_r <= word_nxt;
    end
  end

  assign word_sel = word_r;
  assign last_word = (word_r == 3'd4);

endmodule

// ===== rtl/core/sha1_stream_digest_top.sv =====
// Channel | Direction | Payload
// in_     | input     | sha1_in_t: data_byte, byte_present, end_of_message
// out_    | output    | sha1_out_t: digest_word, word_index, last_word
//
// A byte is taken while idle; the 64th byte of a block starts 80 rounds on the
// shared round unit. An end beat pads one byte per cycle (at most 72 bytes
// over one or two blocks) plus 80 rounds per padded block, then emits five
// beats.
// Synchronous active-low reset restores the initial chaining words.
// in_stall is high while a block compresses, pads or the digest drains;
// out_stall holds the current digest beat.
module sha1_stream_digest_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sha1_pkg::sha1_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sha1_pkg::sha1_out_t out_data
);
  import sha1_pkg::*;

  sha1_cmd_t   cmd;
  sha1_stat_t  stat;
  logic [2:0]  word_sel;
  logic        last_word;
  logic [31:0] digest_word;

  sha1_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .word_sel(word_sel), .last_word(last_word), .cmd(cmd), .stat(stat)
  );

  sha1_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .word_sel(word_sel),
    .stat(stat), .digest_word(digest_word)
  );

  always_comb begin
    out_data.digest_word = digest_word;
    out_data.word_index = word_sel;
    out_data.last_word = last_word;
  end

endmodule
